FILE: rtl/sfr_pkg.sv
// Package for the sweep record framer: action, kind and run-state codes,
// field widths and the word-set struct passed from the sweep core to the emitter.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned ChanW  = 16;
  localparam int unsigned CountW = 17;
  localparam int unsigned TsW    = 32;
  localparam int unsigned WordW  = 16;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_STOP   = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  localparam logic [1:0] KIND_TS_LO = 2'd0;
  localparam logic [1:0] KIND_TS_HI = 2'd1;
  localparam logic [1:0] KIND_POWER = 2'd2;

  localparam logic [1:0] RUN_NEW      = 2'd0;
  localparam logic [1:0] RUN_ACTIVE   = 2'd1;
  localparam logic [1:0] RUN_FINISHED = 2'd2;

  localparam logic [1:0] CFG_START_CH = 2'd0;
  localparam logic [1:0] CFG_STEP     = 2'd1;
  localparam logic [1:0] CFG_STOP_CH  = 2'd2;
  localparam logic [1:0] CFG_SWEEPS   = 2'd3;

  // Words produced by one sample
  typedef struct packed {
    logic             has_ts;
    logic             stop;
    logic [TsW-1:0]   ts;
    logic [WordW-1:0] power;
  } word_set_t;

endpackage

FILE: rtl/sfr_core.sv
// Sweep core: configuration registers, channel / sweep counters and run state.
// Decides per input word which output words it causes. Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [sfr_pkg::CountW-1:0]     cfg_wdata_i,
  input  logic [1:0]                     action_i,
  input  logic [sfr_pkg::WordW-1:0]      power_i,
  input  logic [sfr_pkg::TsW-1:0]        ts_i,
  input  logic                           step_i,
  output logic                           has_words_o,
  output sfr_pkg::word_set_t             words_o
);
  import sfr_pkg::*;

  logic [ChanW-1:0]  start_ch_q, step_q, stop_ch_q;
  logic [CountW-1:0] sweep_cnt_q;
  logic [CountW-1:0] channel_q, channel_d;
  logic [CountW-1:0] sweeps_q, sweeps_d;
  logic [1:0]        run_q, run_d;

  logic [CountW-1:0] start_ext, next_ch;
  logic              at_start, reach, neg, more, sample, fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_ch_q  <= '0;
      step_q      <= ChanW'(1);
      stop_ch_q   <= ChanW'(1);
      sweep_cnt_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_CH: start_ch_q  <= cfg_wdata_i[ChanW-1:0];
        CFG_STEP:     step_q      <= cfg_wdata_i[ChanW-1:0];
        CFG_STOP_CH:  stop_ch_q   <= cfg_wdata_i[ChanW-1:0];
        CFG_SWEEPS:   sweep_cnt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign start_ext = {1'b0, start_ch_q};
  assign at_start  = channel_q == start_ext;
  assign next_ch   = channel_q + {1'b0, step_q};
  assign reach     = next_ch >= {1'b0, stop_ch_q};
  assign neg       = sweeps_q[CountW-1];
  assign more      = !neg && (sweeps_q > CountW'(1));
  assign sample    = (action_i == ACT_SAMPLE) && (run_q == RUN_ACTIVE);
  assign fin       = sample && reach && !neg && !more;

  always_comb begin
    channel_d = channel_q;
    sweeps_d  = sweeps_q;
    run_d     = run_q;
    unique case (action_i)
      ACT_START: begin
        channel_d = start_ext;
        sweeps_d  = sweep_cnt_q;
        run_d     = RUN_ACTIVE;
      end
      ACT_STOP: begin
        sweeps_d = '0;
      end
      ACT_SAMPLE: begin
        if (run_q == RUN_ACTIVE) begin
          if (!reach) begin
            channel_d = next_ch;
          end else if (neg) begin
            channel_d = start_ext;
          end else if (more) begin
            sweeps_d  = sweeps_q - CountW'(1);
            channel_d = start_ext;
          end else begin
            channel_d = next_ch;
            run_d     = RUN_FINISHED;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q <= '0;
      sweeps_q  <= '0;
      run_q     <= RUN_NEW;
    end else if (step_i) begin
      channel_q <= channel_d;
      sweeps_q  <= sweeps_d;
      run_q     <= run_d;
    end
  end

  assign has_words_o    = sample;
  assign words_o.has_ts = at_start;
  assign words_o.stop   = fin;
  assign words_o.ts     = ts_i;
  assign words_o.power  = power_i;

  a_fin_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && fin |=> run_q == RUN_FINISHED)
    else $error("finished sample did not end the run");

  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && action_i == ACT_START |=> run_q == RUN_ACTIVE && channel_q[CountW-1] == 1'b0)
    else $error("start did not arm the run");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && action_i == ACT_STOP |=> sweeps_q == '0)
    else $error("stop did not clear remaining sweeps");

endmodule

FILE: rtl/sfr_emit.sv
// Output emitter: holds one sample's word set, sends one word per handshake
// (timestamp low/high if present, then power). Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  sfr_pkg::word_set_t         words_i,
  output logic                       free_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [sfr_pkg::WordW-1:0]  word_o,
  output logic [1:0]                 kind_o,
  output logic                       last_o,
  output logic                       stop_o
);
  import sfr_pkg::*;

  // words still to send: 3 = ts low next, 2 = ts high next, 1 = power next
  logic [1:0] cnt_q, cnt_d;
  word_set_t  set_q;

  assign m_valid_o = cnt_q != 2'd0;
  assign free_o    = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = words_i.has_ts ? 2'd3 : 2'd1;
    end else if (m_valid_o && m_ready_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      set_q <= words_i;
    end
  end

  always_comb begin
    word_o = set_q.power;
    kind_o = KIND_POWER;
    unique case (cnt_q)
      2'd3: begin
        word_o = set_q.ts[WordW-1:0];
        kind_o = KIND_TS_LO;
      end
      2'd2: begin
        word_o = set_q.ts[TsW-1:WordW];
        kind_o = KIND_TS_HI;
      end
      default: ;
    endcase
  end

  assign last_o = cnt_q == 2'd1;
  assign stop_o = last_o && set_q.stop;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("word set loaded over unsent words");

  a_last_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && last_o |-> kind_o == KIND_POWER)
    else $error("last word is not the power word");

  a_ts_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && m_ready_i && kind_o == KIND_TS_LO |=> m_valid_o && kind_o == KIND_TS_HI)
    else $error("timestamp high half does not follow low half");

endmodule

FILE: rtl/sweep_record_framer.sv
// Sweep record framer top level: input word register and handshake, sweep core,
// output emitter. Depends on sfr_pkg, sfr_core, sfr_emit.
// The input word is registered, then the words it causes load into the emitter.
// One sample per cycle while the emitter is free; a sample at sweep start sends
// 3 words, others the power word only; start, stop and ignored words send none.
// Reset: asynchronous, clears counters and run state, loads register defaults.
`timescale 1ns / 1ps

module sweep_record_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // power[15:0], timestamp[47:16]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // word[15:0], stop[16], zero[23:17]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast
);
  import sfr_pkg::*;

  logic             in_valid_q;
  logic [1:0]       action_q;
  logic [WordW-1:0] power_q;
  logic [TsW-1:0]   ts_q;

  logic       has_words, em_free, advance, load;
  word_set_t  words;
  logic [WordW-1:0] word;
  logic       stop;

  assign advance       = in_valid_q && (!has_words || em_free);
  assign load          = advance && has_words;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      action_q <= s_axis_tuser;
      power_q  <= s_axis_tdata[WordW-1:0];
      ts_q     <= s_axis_tdata[WordW+TsW-1:WordW];
    end
  end

  sfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (action_q),
    .power_i     (power_q),
    .ts_i        (ts_q),
    .step_i      (advance),
    .has_words_o (has_words),
    .words_o     (words)
  );

  sfr_emit u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .words_i   (words),
    .free_o    (em_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .word_o    (word),
    .kind_o    (m_axis_tuser),
    .last_o    (m_axis_tlast),
    .stop_o    (stop)
  );

  assign m_axis_tdata = {7'd0, stop, word};

endmodule
